[hw/rtl/fce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fce_pkg
// Shared types and constants of the allocation table chain engine.
// ----------------------------------------------------------------------------
package fce_pkg;

    localparam int NUM_BLOCKS = 2048;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int ENT_W      = 16;
    localparam int STEP_W     = $clog2(NUM_BLOCKS + 1);
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;

    typedef logic [ENT_W-1:0]  entry_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam entry_t ENT_FREE    = 16'h0000;
    localparam entry_t ENT_END     = 16'hFFFF;
    localparam addr_t  FIRST_ALLOC = ADDR_W'(2);
    localparam addr_t  LAST_BLOCK  = ADDR_W'(NUM_BLOCKS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_FORMAT = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_FREE   = 3'd2,
        OP_APPEND = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_WALK = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_LINK,
        S_FREE,
        S_APP,
        S_APP_CHK,
        S_READ,
        S_RESP
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/fce_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fce_req_if / fce_rsp_if
// Valid/ready channels for requests and results of the chain engine.
// ----------------------------------------------------------------------------
interface fce_req_if;
    import fce_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] block;
    logic [ADDR_W-1:0] other_block;
    logic              link_after;

    modport source (
        output valid, operation, block, other_block, link_after,
        input  ready
    );
    modport sink (
        input  valid, operation, block, other_block, link_after,
        output ready
    );
endinterface

interface fce_rsp_if;
    import fce_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_block;
    logic              chain_end;
    logic              entry_free;
    logic [STAT_W-1:0] status;

    modport source (
        output valid, result_block, chain_end, entry_free, status,
        input  ready
    );
    modport sink (
        input  valid, result_block, chain_end, entry_free, status,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/fat_chain_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_engine
// Allocation table manager: format, allocate, free chain, append, read.
// ----------------------------------------------------------------------------
// The table sits in one single-port-write, single-port-read RAM with a
// registered read port; one request word is worked at a time and gives one
// result word. After reset the block runs a clearing pass over all
// NUM_BLOCKS (2048) entries before it takes the first word. Format reruns
// the clearing pass and then gives its result word. Allocate scans one
// entry per cycle from block 2 up to the last block. Free chain and append
// walk one chain link per cycle (one RAM read each), up to NUM_BLOCKS links;
// append then checks the attached block in a state of its own before it
// links it. The result sits in an output register, so the next request word
// is taken while the previous result word still waits.
// ----------------------------------------------------------------------------
module fat_chain_engine (
    input  logic      clk,
    input  logic      rst_n,
    fce_req_if.sink   req,
    fce_rsp_if.source rsp
);
    import fce_pkg::*;

    state_t              state_reg, state_next;
    addr_t               clr_reg, clr_next;
    logic                fmt_reg, fmt_next;
    addr_t               blk_reg, blk_next;
    addr_t               oth_reg, oth_next;
    logic                link_reg, link_next;
    entry_t              cur_reg, cur_next;
    addr_t               chk_reg, chk_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;

    addr_t               pblk_reg, pblk_next;
    logic                pend_end_reg, pend_end_next;
    logic                pend_free_reg, pend_free_next;
    status_t             pst_reg, pst_next;

    logic                out_valid_reg, out_valid_next;
    addr_t               out_block_reg, out_block_next;
    logic                out_end_reg, out_end_next;
    logic                out_free_reg, out_free_next;
    status_t             out_status_reg, out_status_next;

    entry_t              mem [NUM_BLOCKS];
    entry_t              mem_q_reg;
    entry_t              byp_data_reg;
    logic                byp_hit_reg;
    logic                mem_we, mem_re;
    addr_t               waddr, raddr;
    entry_t              wdata;
    entry_t              rdata;

    addr_t               cur_addr;
    logic                cur_oor;
    logic                walk_bad;
    logic                oth_bad;

    // RAM with write-to-read bypass for same-cycle access to one entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[raddr];
        end
        byp_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= mem_re && mem_we && (waddr == raddr);
        end
    end

    assign rdata    = byp_hit_reg ? byp_data_reg : mem_q_reg;
    assign cur_addr = cur_reg[ADDR_W-1:0];
    assign cur_oor  = cur_reg >= ENT_W'(NUM_BLOCKS);
    assign walk_bad = (steps_reg == STEP_W'(NUM_BLOCKS)) || cur_oor || (rdata == ENT_FREE);
    assign oth_bad  = (oth_reg == '0) || (oth_reg > LAST_BLOCK) || (rdata == ENT_FREE)
                      || (ENT_W'(oth_reg) == cur_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            fmt_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fmt_reg       <= fmt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg        <= blk_next;
        oth_reg        <= oth_next;
        link_reg       <= link_next;
        cur_reg        <= cur_next;
        chk_reg        <= chk_next;
        steps_reg      <= steps_next;
        pblk_reg       <= pblk_next;
        pend_end_reg   <= pend_end_next;
        pend_free_reg  <= pend_free_next;
        pst_reg        <= pst_next;
        out_block_reg  <= out_block_next;
        out_end_reg    <= out_end_next;
        out_free_reg   <= out_free_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        fmt_next        = fmt_reg;
        blk_next        = blk_reg;
        oth_next        = oth_reg;
        link_next       = link_reg;
        cur_next        = cur_reg;
        chk_next        = chk_reg;
        steps_next      = steps_reg;
        pblk_next       = pblk_reg;
        pend_end_next   = pend_end_reg;
        pend_free_next  = pend_free_reg;
        pst_next        = pst_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_block_next  = out_block_reg;
        out_end_next    = out_end_reg;
        out_free_next   = out_free_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        waddr           = cur_addr;
        raddr           = cur_addr;
        wdata           = ENT_FREE;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                waddr  = clr_reg;
                wdata  = (clr_reg < FIRST_ALLOC) ? ENT_END : ENT_FREE;
                if (clr_reg == LAST_BLOCK)
                begin
                    state_next = fmt_reg ? S_RESP : S_IDLE;
                    fmt_next   = 1'b0;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    blk_next       = req.block;
                    oth_next       = req.other_block;
                    link_next      = req.link_after;
                    cur_next       = ENT_W'(req.block);
                    steps_next     = '0;
                    pblk_next      = '0;
                    pend_end_next  = 1'b0;
                    pend_free_next = 1'b0;
                    pst_next       = ST_OK;
                    raddr          = req.block;
                    unique case (op_t'(req.operation))
                        OP_FORMAT:
                        begin
                            clr_next   = '0;
                            fmt_next   = 1'b1;
                            state_next = S_CLEAR;
                        end
                        OP_ALLOC:
                        begin
                            mem_re     = 1'b1;
                            raddr      = FIRST_ALLOC;
                            chk_next   = FIRST_ALLOC;
                            state_next = S_ALLOC;
                        end
                        OP_FREE:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_FREE;
                        end
                        OP_APPEND:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_APP;
                        end
                        OP_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (rdata == ENT_FREE)
                begin
                    mem_we    = 1'b1;
                    waddr     = chk_reg;
                    wdata     = ENT_END;
                    pblk_next = chk_reg;
                    if (link_reg && (blk_reg <= LAST_BLOCK) && (blk_reg != chk_reg))
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (chk_reg == LAST_BLOCK)
                begin
                    pst_next   = ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_re   = 1'b1;
                    raddr    = chk_reg + ADDR_W'(1);
                    chk_next = chk_reg + ADDR_W'(1);
                end
            end

            S_LINK:
            begin
                mem_we     = 1'b1;
                waddr      = blk_reg;
                wdata      = ENT_W'(pblk_reg);
                state_next = S_RESP;
            end

            S_FREE:
            begin
                if (walk_bad)
                begin
                    pst_next   = ST_WALK;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_we = 1'b1;
                    waddr  = cur_addr;
                    wdata  = ENT_FREE;
                    if (rdata == ENT_END)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        raddr      = rdata[ADDR_W-1:0];
                        cur_next   = rdata;
                        steps_next = steps_reg + STEP_W'(1);
                    end
                end
            end

            S_APP:
            begin
                if (walk_bad)
                begin
                    pst_next   = ST_WALK;
                    state_next = S_RESP;
                end
                else if (rdata == ENT_END)
                begin
                    mem_re     = 1'b1;
                    raddr      = oth_reg;
                    state_next = S_APP_CHK;
                end
                else
                begin
                    mem_re     = 1'b1;
                    raddr      = rdata[ADDR_W-1:0];
                    cur_next   = rdata;
                    steps_next = steps_reg + STEP_W'(1);
                end
            end

            S_APP_CHK:
            begin
                pblk_next  = cur_addr;
                state_next = S_RESP;
                if (oth_bad)
                begin
                    pst_next = ST_WALK;
                end
                else
                begin
                    mem_we = 1'b1;
                    waddr  = cur_addr;
                    wdata  = ENT_W'(oth_reg);
                end
            end

            S_READ:
            begin
                state_next = S_RESP;
                if (cur_oor)
                begin
                    pst_next = ST_WALK;
                end
                else if (rdata == ENT_FREE)
                begin
                    pend_free_next = 1'b1;
                end
                else if (rdata == ENT_END)
                begin
                    pend_end_next = 1'b1;
                end
                else
                begin
                    pblk_next = rdata[ADDR_W-1:0];
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_block_next  = pblk_reg;
                    out_end_next    = pend_end_reg;
                    out_free_next   = pend_free_reg;
                    out_status_next = pst_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_block = out_block_reg;
    assign rsp.chain_end    = out_end_reg;
    assign rsp.entry_free   = out_free_reg;
    assign rsp.status       = out_status_reg;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("table written while idle");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_RESP))
        else $error("result word raised outside response state");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE || state_reg == S_APP) |-> steps_reg <= STEP_W'(NUM_BLOCKS))
        else $error("chain walk step count beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("request word taken without leaving idle");
`endif

endmodule
`default_nettype wire
